@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files; the top-level module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KIC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/kic_pkg.sv @@
// Types, constants and kernel coefficients of the image convolution block.
package kic_pkg;
    localparam logic [1:0] MODE_GAUSS = 2'd0;
    localparam logic [1:0] MODE_SOBX  = 2'd1;
    localparam logic [1:0] MODE_SOBY  = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam int CFG_W  = 11;
    localparam int PIX_W  = 8;
    localparam int FILT_W = 10;
    localparam int PROD_W = 13;
    localparam int SUM_W  = 16;
    localparam int QUO_W  = 5;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [10:0] RST_HEIGHT = 11'd480;

    // floor(x/159) == (x*3298) >> 19 for every x up to 15*255.
    localparam logic [11:0] RECIP_159   = 12'd3298;
    localparam int          RECIP_SHIFT = 19;

    localparam logic signed [4:0] GAUSS_K [5][5] = '{
        '{5'sd2, 5'sd4, 5'sd5, 5'sd4, 5'sd2},
        '{5'sd4, 5'sd9, 5'sd12, 5'sd9, 5'sd4},
        '{5'sd5, 5'sd12, 5'sd15, 5'sd12, 5'sd5},
        '{5'sd4, 5'sd9, 5'sd12, 5'sd9, 5'sd4},
        '{5'sd2, 5'sd4, 5'sd5, 5'sd4, 5'sd2}
    };
    localparam logic signed [4:0] SOBX_K [3][3] = '{
        '{-5'sd1, 5'sd0, 5'sd1},
        '{-5'sd2, 5'sd0, 5'sd2},
        '{-5'sd1, 5'sd0, 5'sd1}
    };
    localparam logic signed [4:0] SOBY_K [3][3] = '{
        '{5'sd1, 5'sd2, 5'sd1},
        '{5'sd0, 5'sd0, 5'sd0},
        '{-5'sd1, -5'sd2, -5'sd1}
    };

    typedef struct packed {
        logic       emit;
        logic       eor;
        logic       eof;
        logic [1:0] mode;
    } t_ctl;

    typedef struct packed {
        logic valid;
        logic col0;
        t_ctl ctl;
    } t_stage;

    typedef struct packed {
        logic flushing;
        logic flush_last;
    } t_front_stat;

    // Coefficient at row age k and column age m of the flipped kernel.
    function automatic logic signed [4:0] coef(input logic [1:0] mode, input int k,
                                               input int m);
        logic signed [4:0] c;
        c = 5'sd0;
        case (mode)
            MODE_GAUSS: c = GAUSS_K[k][m];
            MODE_SOBX:  if (k < 3 && m < 3) c = SOBX_K[k][m];
            MODE_SOBY:  if (k < 3 && m < 3) c = SOBY_K[k][m];
            default:    c = 5'sd0;
        endcase
        return c;
    endfunction
endpackage

@@ rtl/kic_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module kic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
endmodule

@@ rtl/kic_front.sv @@
// Raster counters, row-end flush sequencer and line store; produces one window column a step.
module kic_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int KERNEL_SIZE = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_valid,
    input  logic [kic_pkg::PIX_W-1:0]  i_pixel,
    output logic                       o_ready,
    input  logic [1:0]                 i_cfg_mode,
    input  logic [kic_pkg::CFG_W-1:0]  i_cfg_width,
    input  logic [kic_pkg::CFG_W-1:0]  i_cfg_height,
    output kic_pkg::t_stage            o_stage,
    output logic [kic_pkg::PIX_W-1:0]  o_column [KERNEL_SIZE],
    output kic_pkg::t_front_stat       o_stat
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int SW = $clog2(KERNEL_SIZE);
    localparam int WW = KERNEL_SIZE * kic_pkg::PIX_W;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [SW-1:0] r_slot;
    logic [1:0]    r_flush;
    logic          r_flast;
    logic [1:0]    r_mode;
    logic [CW:0]   r_w;
    logic [RW-1:0] r_h;
    logic [1:0]    r_half;

    logic [CW:0]   cfg_w;
    logic [RW-1:0] cfg_h;
    logic [1:0]    cfg_mode;
    logic          start;
    logic [1:0]    cur_mode;
    logic [CW:0]   cur_w;
    logic [RW-1:0] cur_h;
    logic [1:0]    cur_half;
    logic          acc;
    logic          flush_ev;
    logic          last_col;
    logic          row_ok;
    logic          emit_real;
    logic          emit_f;
    logic [1:0]    f_idx;
    logic [KERNEL_SIZE-1:0] mask;
    logic [RW-1:0] n_row;
    logic [WW-1:0] ram_q;
    logic [WW-1:0] col_word;
    logic [WW-1:0] wr_word;
    logic          wr_en;

    logic                      r_a_valid;
    logic                      r_a_flush;
    logic                      r_a_col0;
    logic                      r_a_wr;
    logic [CW-1:0]             r_a_addr;
    logic [kic_pkg::PIX_W-1:0] r_a_pix;
    logic [SW-1:0]             r_a_slot;
    logic [KERNEL_SIZE-1:0]    r_a_mask;
    kic_pkg::t_ctl             r_a_ctl;
    kic_pkg::t_ctl             ctl;
    logic                      r_fwd;
    logic [WW-1:0]             r_fwd_word;

    // Clamp frame registers; fold mode 3 onto the Gaussian, or both onto Sobel X below 5x5.
    always_comb begin
        if (i_cfg_width == '0) cfg_w = (CW+1)'(1);
        else if (int'(i_cfg_width) > MAX_WIDTH) cfg_w = (CW+1)'(MAX_WIDTH);
        else cfg_w = (CW+1)'(i_cfg_width);
        if (i_cfg_height == '0) cfg_h = RW'(1);
        else if (int'(i_cfg_height) > MAX_HEIGHT) cfg_h = RW'(MAX_HEIGHT);
        else cfg_h = RW'(i_cfg_height);
        cfg_mode = i_cfg_mode;
        if (cfg_mode != kic_pkg::MODE_SOBX && cfg_mode != kic_pkg::MODE_SOBY) begin
            cfg_mode = (KERNEL_SIZE < 5) ? kic_pkg::MODE_SOBX : kic_pkg::MODE_GAUSS;
        end
    end

    assign start    = (r_row == '0) && (r_col == '0);
    assign cur_mode = start ? cfg_mode : r_mode;
    assign cur_w    = start ? cfg_w : r_w;
    assign cur_h    = start ? cfg_h : r_h;
    assign cur_half = (cur_mode == kic_pkg::MODE_GAUSS) ? 2'd2 : 2'd1;

    assign o_ready  = i_advance && (r_flush == 2'd0);
    assign acc      = i_valid && o_ready;
    assign flush_ev = i_advance && (r_flush != 2'd0);

    assign last_col  = ({1'b0, r_col} == cur_w - (CW+1)'(1));
    assign row_ok    = r_row < cur_h;
    assign emit_real = (r_row >= RW'(cur_half)) && (r_col >= CW'(cur_half));
    assign f_idx     = r_half - r_flush;
    assign emit_f    = ((CW+2)'(r_w) + (CW+2)'(f_idx)) >= (CW+2)'(r_half);
    assign n_row     = r_row + RW'(1);

    always_comb begin
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            mask[k] = (r_row >= RW'(k)) && ((r_row - RW'(k)) < cur_h);
        end
        if (r_flush != 2'd0) begin
            ctl.emit = emit_f;
            ctl.eor  = (r_flush == 2'd1);
            ctl.eof  = (r_flush == 2'd1) && r_flast;
            ctl.mode = r_mode;
        end else begin
            ctl.emit = emit_real;
            ctl.eor  = 1'b0;
            ctl.eof  = 1'b0;
            ctl.mode = cur_mode;
        end
    end

    // Each address holds one column of the last rows, one byte per slot. The column read
    // for a request is written back with its pixel merged in when the request moves on;
    // a read of that same column at the same edge takes the merged word from r_fwd_word.
    always_comb begin
        col_word = r_fwd ? r_fwd_word : ram_q;
        wr_word  = col_word;
        for (int s = 0; s < KERNEL_SIZE; s++) begin
            if (r_a_slot == SW'(s)) wr_word[s*kic_pkg::PIX_W +: kic_pkg::PIX_W] = r_a_pix;
        end
    end

    assign wr_en = i_advance && r_a_valid && r_a_wr;

    kic_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_a_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (i_advance),
        .i_rd_addr (r_col),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_slot    <= '0;
            r_flush   <= 2'd0;
            r_flast   <= 1'b0;
            r_mode    <= kic_pkg::MODE_GAUSS;
            r_w       <= (CW+1)'(1);
            r_h       <= RW'(1);
            r_half    <= 2'd2;
            r_a_valid <= 1'b0;
        end else begin
            if (i_advance) begin
                r_a_valid <= acc || flush_ev;
            end
            if (flush_ev) begin
                r_flush <= r_flush - 2'd1;
            end
            if (acc) begin
                if (start) begin
                    r_mode <= cur_mode;
                    r_w    <= cur_w;
                    r_h    <= cur_h;
                    r_half <= cur_half;
                end
                if (last_col) begin
                    r_col   <= '0;
                    r_flush <= (r_row >= RW'(cur_half)) ? cur_half : 2'd0;
                    r_flast <= (r_row == cur_h - RW'(1) + RW'(cur_half));
                    if (n_row >= cur_h + RW'(cur_half)) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= n_row;
                        r_slot <= (r_slot == SW'(KERNEL_SIZE - 1)) ? '0 : r_slot + SW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_flush  <= flush_ev;
            r_a_col0   <= acc && (r_col == '0);
            r_a_wr     <= acc && row_ok;
            r_a_addr   <= r_col;
            r_a_pix    <= i_pixel;
            r_a_slot   <= r_slot;
            r_a_mask   <= mask;
            r_a_ctl    <= ctl;
            r_fwd      <= wr_en && (r_a_addr == r_col);
            r_fwd_word <= wr_word;
        end
    end

    // Row age k lives in the slot k places behind the current one.
    always_comb begin
        int sl;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            if (r_a_slot >= SW'(k)) sl = int'(r_a_slot) - k;
            else sl = int'(r_a_slot) + KERNEL_SIZE - k;
            if (r_a_flush || !r_a_mask[k]) begin
                o_column[k] = '0;
            end else if (k == 0) begin
                o_column[k] = r_a_pix;
            end else begin
                o_column[k] = col_word[sl*kic_pkg::PIX_W +: kic_pkg::PIX_W];
            end
        end
    end

    assign o_stage.valid = r_a_valid;
    assign o_stage.col0  = r_a_col0;
    assign o_stage.ctl   = r_a_ctl;
    assign o_stat.flushing   = (r_flush != 2'd0);
    assign o_stat.flush_last = (r_flush == 2'd1);
endmodule

@@ rtl/kic_filter.sv @@
// Pixel window and the multiply, divide, sum and magnitude pipeline.
module kic_filter #(
    parameter int KERNEL_SIZE = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  kic_pkg::t_stage            i_stage,
    input  logic [kic_pkg::PIX_W-1:0]  i_column [KERNEL_SIZE],
    output logic                       o_valid,
    output logic [kic_pkg::FILT_W-1:0] o_filtered,
    output logic                       o_eor,
    output logic                       o_eof
);
    localparam int PW = kic_pkg::PROD_W;
    localparam int SUMW = kic_pkg::SUM_W;

    logic [kic_pkg::PIX_W-1:0] r_win [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PW-1:0]      r_prod [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PW-1:0]      r_term [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [SUMW-1:0]    r_rsum [KERNEL_SIZE];
    logic signed [SUMW-1:0]    row_sum [KERNEL_SIZE];
    logic signed [SUMW-1:0]    total;
    logic signed [SUMW-1:0]    mag;
    logic [23:0]               quo_full [KERNEL_SIZE][KERNEL_SIZE];

    logic          r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_out_valid;
    kic_pkg::t_ctl r_b_ctl, r_c_ctl, r_d_ctl, r_e_ctl;
    logic [kic_pkg::FILT_W-1:0] r_out_data;
    logic          r_out_eor, r_out_eof;

    always_comb begin
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            for (int m = 0; m < KERNEL_SIZE; m++) begin
                quo_full[k][m] = 24'(r_prod[k][m][11:0]) * 24'(kic_pkg::RECIP_159);
            end
        end
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            row_sum[k] = '0;
            for (int m = 0; m < KERNEL_SIZE; m++) begin
                row_sum[k] = row_sum[k] + SUMW'(r_term[k][m]);
            end
        end
        total = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            total = total + r_rsum[k];
        end
        mag = (total < 0) ? -total : total;
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            // New column enters at age zero; column zero of a row starts from blank.
            if (i_stage.valid) begin
                for (int k = 0; k < KERNEL_SIZE; k++) begin
                    r_win[k][0] <= i_column[k];
                    for (int m = 1; m < KERNEL_SIZE; m++) begin
                        r_win[k][m] <= i_stage.col0 ? '0 : r_win[k][m-1];
                    end
                end
            end
            r_b_ctl <= i_stage.ctl;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                for (int m = 0; m < KERNEL_SIZE; m++) begin
                    r_prod[k][m] <= PW'(kic_pkg::coef(r_b_ctl.mode, k, m))
                                    * PW'($signed({1'b0, r_win[k][m]}));
                    if (r_c_ctl.mode == kic_pkg::MODE_GAUSS) begin
                        r_term[k][m] <= PW'(quo_full[k][m][kic_pkg::RECIP_SHIFT +: kic_pkg::QUO_W]);
                    end else begin
                        r_term[k][m] <= r_prod[k][m];
                    end
                end
            end
            r_c_ctl <= r_b_ctl;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                r_rsum[k] <= row_sum[k];
            end
            r_d_ctl    <= r_c_ctl;
            r_e_ctl    <= r_d_ctl;
            r_out_data <= mag[kic_pkg::FILT_W-1:0];
            r_out_eor  <= r_e_ctl.eor;
            r_out_eof  <= r_e_ctl.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_b_valid   <= i_stage.valid && i_stage.ctl.emit;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;
    assign o_eor      = r_out_eor;
    assign o_eof      = r_out_eof;
endmodule

@@ rtl/kernel_image_convolution.sv @@
// Streaming 2-D convolution of an 8-bit raster image with a 5x5 Gaussian (divisor 159) or a
// 3x3 Sobel kernel, emitting the magnitude of each output pixel. One pixel request is taken
// per clock while the output is not stalled; at the end of every row that completes an output
// row the input is held while the right-hand border columns (half the kernel size: two for the
// Gaussian, one for Sobel) are emitted. A result passes the front stage, window, product, term
// and row-sum registers on its way into the output register.
// Mode and frame size are sampled at the first pixel of each frame; after the frame the host
// sends half-kernel-size rows of drain requests whose pixel values are ignored. The line
// store is one memory with a column of the last rows at each address and needs no clearing.
module kernel_image_convolution #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int KERNEL_SIZE = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] filtered, [15:10] zero
    output logic        m_axis_tlast,   // end_of_row
    output logic [0:0]  m_axis_tuser,   // [0] end_of_frame
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    `include "assert_macros.svh"

    logic [1:0]                r_kernel_mode;
    logic [kic_pkg::CFG_W-1:0] r_frame_width;
    logic [kic_pkg::CFG_W-1:0] r_frame_height;
    logic                      advance;
    kic_pkg::t_stage           stage;
    kic_pkg::t_front_stat      stat;
    logic [kic_pkg::PIX_W-1:0] column [KERNEL_SIZE];
    logic [kic_pkg::FILT_W-1:0] filtered;
    logic                      eor, eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode  <= kic_pkg::MODE_GAUSS;
            r_frame_width  <= kic_pkg::RST_WIDTH;
            r_frame_height <= kic_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kic_pkg::REG_MODE:   r_kernel_mode  <= i_cfg_data[1:0];
                kic_pkg::REG_WIDTH:  r_frame_width  <= i_cfg_data;
                kic_pkg::REG_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the output register can take a result.
    assign advance = !m_axis_tvalid || m_axis_tready;

    kic_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_valid      (s_axis_tvalid),
        .i_pixel      (s_axis_tdata),
        .o_ready      (s_axis_tready),
        .i_cfg_mode   (r_kernel_mode),
        .i_cfg_width  (r_frame_width),
        .i_cfg_height (r_frame_height),
        .o_stage      (stage),
        .o_column     (column),
        .o_stat       (stat)
    );

    kic_filter #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_stage    (stage),
        .i_column   (column),
        .o_valid    (m_axis_tvalid),
        .o_filtered (filtered),
        .o_eor      (eor),
        .o_eof      (eof)
    );

    assign m_axis_tdata = {6'b0, filtered};
    assign m_axis_tlast = eor;
    assign m_axis_tuser = eof;

    `KIC_ASSERT_IMPL(a_stall_holds_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `KIC_ASSERT_IMPL(a_flush_holds_input, i_clk, i_rst_n, stat.flushing, !s_axis_tready)
    `KIC_ASSERT_IMPL(a_frame_end_is_row_end, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    `KIC_ASSERT_NEXT(a_flush_ends, i_clk, i_rst_n, stat.flush_last && advance, !stat.flushing)
endmodule
